// ===== sv/pss_pkg.sv =====
// pss_pkg: shared types, constants and helper functions for the path sanitizer stream
// used by pss_front, pss_queue, pss_back and path_sanitizer_stream_unit
// no dependencies
package pss_pkg;

    // default longest path in bytes
    localparam int DEF_MAX_PATH_LEN = 1024;

    // queue between the front and the back part (power of two)
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_ALLOW_SUBDIRS = 1'd0;

    // character codes
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // final status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_TOO_LONG   = 3'd2,
        ST_EMPTY_TRIM = 3'd3,
        ST_TRAVERSAL  = 3'd4,
        ST_ILLEGAL    = 3'd5,
        ST_SUBDIR     = 3'd6
    } t_status;

    // front part: drive prefix detection
    typedef enum logic [1:0] {
        FP_FIRST = 2'd0,
        FP_HOLD  = 2'd1,
        FP_PASS  = 2'd2
    } t_front_phase;

    // back part: operation taken from a queue entry
    typedef enum logic [1:0] {
        OP_BYTE0 = 2'd0,
        OP_BYTE1 = 2'd1,
        OP_FINAL = 2'd2
    } t_op;

    typedef struct packed {
        logic       has_char;
        logic [7:0] ch;
        logic       end_of_path;
    } t_in_item;

    typedef struct packed {
        logic        is_final;
        logic [7:0]  out_byte;
        logic [9:0]  out_index;
        logic [10:0] norm_length;
        t_status     status;
        logic        last_result;
    } t_out_item;

    // classified work for the back part: up to two bytes and an optional path end
    typedef struct packed {
        logic       byte0_vld;
        logic [7:0] byte0;
        logic       byte1_vld;
        logic [7:0] byte1;
        logic       end_of_path;
        logic       empty;
        logic       too_long;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic traversal;
        logic illegal;
        logic slash;
    } t_err_flags;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_whitelisted(logic [7:0] c);
        return is_letter(c) || (c >= 8'h30 && c <= 8'h39) ||
               c == CH_SLASH || c == CH_DOT || c == 8'h5F || c == 8'h2D ||
               c == CH_SPACE || c == 8'h28 || c == 8'h29 || c == 8'h2B || c == 8'h2C;
    endfunction

endpackage

// ===== sv/pss_front.sv =====
// pss_front: counts raw bytes, maps backslash, drops a drive prefix
// and packs the work of one transaction into a queue entry; depends on pss_pkg
module pss_front
    import pss_pkg::*;
#(
    parameter int MAX_PATH_LEN = DEF_MAX_PATH_LEN
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_q_entry o_entry
);

    localparam int CNT_W = $clog2(MAX_PATH_LEN + 2);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PATH_LEN);

    logic [CNT_W-1:0] r_raw_cnt, n_raw_cnt;
    logic [7:0]       r_held, n_held;
    t_front_phase     r_phase, n_phase;

    logic [CNT_W-1:0] raw_inc;
    logic             proc;
    logic [7:0]       mapped;
    logic             prefix;

    // byte count, saturating one past the limit
    assign raw_inc = (i_item.has_char && r_raw_cnt <= MAX_CNT) ? r_raw_cnt + CNT_W'(1)
                                                                : r_raw_cnt;
    assign proc    = i_item.has_char && (r_raw_cnt < MAX_CNT);
    assign mapped  = (i_item.ch == CH_BACKSLASH) ? CH_SLASH : i_item.ch;
    assign prefix  = (mapped == CH_COLON) && is_letter(r_held);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_raw_cnt = r_raw_cnt;
        if (i_accept) begin
            n_raw_cnt = raw_inc;
            if (proc) begin
                unique case (r_phase)
                    FP_FIRST: begin
                        n_held  = mapped;
                        n_phase = FP_HOLD;
                    end
                    FP_HOLD:  n_phase = FP_PASS;
                    FP_PASS:  n_phase = FP_PASS;
                    default:  n_phase = FP_FIRST;
                endcase
            end
            if (i_item.end_of_path) begin
                n_phase   = FP_FIRST;
                n_held    = '0;
                n_raw_cnt = '0;
            end
        end
    end

    // queue entry
    always_comb begin
        o_entry             = '0;
        o_entry.end_of_path = i_item.end_of_path;
        o_entry.empty       = (raw_inc == '0);
        o_entry.too_long    = (raw_inc > MAX_CNT);
        if (proc) begin
            unique case (r_phase)
                FP_FIRST: begin
                    // a one-byte path releases its only byte at its end
                    if (i_item.end_of_path) begin
                        o_entry.byte0_vld = 1'b1;
                        o_entry.byte0     = mapped;
                    end
                end
                FP_HOLD: begin
                    if (!prefix) begin
                        o_entry.byte0_vld = 1'b1;
                        o_entry.byte0     = r_held;
                        o_entry.byte1_vld = 1'b1;
                        o_entry.byte1     = mapped;
                    end
                end
                FP_PASS: begin
                    o_entry.byte0_vld = 1'b1;
                    o_entry.byte0     = mapped;
                end
                default: o_entry.byte0_vld = 1'b0;
            endcase
        end else if (r_phase == FP_HOLD && i_item.end_of_path) begin
            o_entry.byte0_vld = 1'b1;
            o_entry.byte0     = r_held;
        end
    end

    assign o_push = i_accept &&
                    (o_entry.byte0_vld || o_entry.byte1_vld || o_entry.end_of_path);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= FP_FIRST;
            r_held    <= '0;
            r_raw_cnt <= '0;
        end else begin
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_raw_cnt <= n_raw_cnt;
        end
    end

endmodule

// ===== sv/pss_queue.sv =====
// pss_queue: short register queue that decouples the front and the back part
// depends on pss_pkg
module pss_queue
    import pss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_entry,
    input  logic      i_pop,
    output t_q_entry  o_head,
    output t_q_status o_status
);

    t_q_entry        r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty  = (r_count == '0);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/pss_back.sv =====
// pss_back: strips, emits and tracks segments one operation per cycle unless the queue is empty
// or the output stalls, builds the final status and holds the output register; depends on pss_pkg
module pss_back
    import pss_pkg::*;
#(
    parameter int MAX_PATH_LEN = DEF_MAX_PATH_LEN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_entry  i_head,
    input  t_q_status i_q_status,
    input  logic      i_allow_subdirs,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int CNT_W = $clog2(MAX_PATH_LEN + 2);
    localparam int EXT_W = CNT_W + 11;

    function automatic logic [1:0] sat_add(logic [1:0] a, logic [1:0] b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[2] ? 2'd3 : s[1:0];
    endfunction

    // path state
    logic             r_emitting, n_emitting;
    logic [CNT_W-1:0] r_emit_cnt, n_emit_cnt;
    logic [CNT_W-1:0] r_commit, n_commit;
    logic             r_pend_slash, n_pend_slash;
    logic [1:0]       r_sp_before, n_sp_before;
    logic [1:0]       r_sp_after, n_sp_after;
    logic [1:0]       r_seg_len, n_seg_len;
    logic             r_seg_dots, n_seg_dots;
    t_err_flags       r_flags, n_flags;
    t_op              r_step, n_step;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    logic       advance;
    t_op        cur_op;
    logic       op_last;
    logic [7:0] cur_byte;
    logic       trim;
    logic       has_result;
    t_out_item  res;
    logic [1:0] seg_l;
    logic       trav_end;
    t_status    st;
    logic [EXT_W-1:0] ext_emit, ext_commit;

    assign advance    = !i_q_status.empty && (!r_out_valid || !i_out_stall);
    assign ext_emit   = EXT_W'(r_emit_cnt);
    assign ext_commit = EXT_W'(r_commit);

    // operation select within the head entry
    always_comb begin
        if (r_step == OP_BYTE0 && i_head.byte0_vld) begin
            cur_op = OP_BYTE0;
        end else if (r_step != OP_FINAL && i_head.byte1_vld) begin
            cur_op = OP_BYTE1;
        end else begin
            cur_op = OP_FINAL;
        end
        unique case (cur_op)
            OP_BYTE0: begin
                op_last  = !(i_head.byte1_vld || i_head.end_of_path);
                n_step   = i_head.byte1_vld ? OP_BYTE1 : OP_FINAL;
                cur_byte = i_head.byte0;
            end
            OP_BYTE1: begin
                op_last  = !i_head.end_of_path;
                n_step   = OP_FINAL;
                cur_byte = i_head.byte1;
            end
            default: begin
                op_last  = 1'b1;
                n_step   = OP_BYTE0;
                cur_byte = i_head.byte0;
            end
        endcase
        if (op_last) begin
            n_step = OP_BYTE0;
        end
    end

    assign o_pop = advance && op_last;
    assign trim  = (cur_byte == CH_SLASH) || (cur_byte == CH_SPACE);

    // end-of-path traversal check and status priority
    assign trav_end = (r_commit != '0) && (r_seg_len == 2'd2) && r_seg_dots;

    always_comb begin
        if (i_head.empty) begin
            st = ST_EMPTY;
        end else if (i_head.too_long) begin
            st = ST_TOO_LONG;
        end else if (r_commit == '0) begin
            st = ST_EMPTY_TRIM;
        end else if (r_flags.traversal || trav_end) begin
            st = ST_TRAVERSAL;
        end else if (r_flags.illegal) begin
            st = ST_ILLEGAL;
        end else if (r_flags.slash && !i_allow_subdirs) begin
            st = ST_SUBDIR;
        end else begin
            st = ST_OK;
        end
    end

    // operation execution
    always_comb begin
        n_emitting   = r_emitting;
        n_emit_cnt   = r_emit_cnt;
        n_commit     = r_commit;
        n_pend_slash = r_pend_slash;
        n_sp_before  = r_sp_before;
        n_sp_after   = r_sp_after;
        n_seg_len    = r_seg_len;
        n_seg_dots   = r_seg_dots;
        n_flags      = r_flags;
        seg_l        = r_seg_len;
        has_result   = 1'b0;
        res          = '0;
        if (cur_op == OP_FINAL) begin
            has_result      = 1'b1;
            res.is_final    = 1'b1;
            res.status      = st;
            res.norm_length = (st == ST_OK) ? ext_commit[10:0] : 11'd0;
            res.last_result = 1'b1;
            // back to the start of a new path
            n_emitting   = 1'b0;
            n_emit_cnt   = '0;
            n_commit     = '0;
            n_pend_slash = 1'b0;
            n_sp_before  = '0;
            n_sp_after   = '0;
            n_seg_len    = '0;
            n_seg_dots   = 1'b1;
            n_flags      = '0;
        end else if (r_emitting || !trim) begin
            // tentative byte
            has_result    = 1'b1;
            res.out_byte  = cur_byte;
            res.out_index = ext_emit[9:0];
            n_emitting    = 1'b1;
            n_emit_cnt    = r_emit_cnt + CNT_W'(1);
            if (trim) begin
                // run of slashes and spaces that may still be trimmed
                if (cur_byte == CH_SLASH) begin
                    n_pend_slash = 1'b1;
                    n_sp_after   = '0;
                end else if (r_pend_slash) begin
                    n_sp_after = sat_add(r_sp_after, 2'd1);
                end else begin
                    n_sp_before = sat_add(r_sp_before, 2'd1);
                end
            end else begin
                // kept byte commits the pending run
                if (r_pend_slash) begin
                    if (r_sp_before == '0 && r_seg_len == 2'd2 && r_seg_dots) begin
                        n_flags.traversal = 1'b1;
                    end
                    n_flags.slash = 1'b1;
                    seg_l         = r_sp_after;
                    n_seg_dots    = (r_sp_after == '0);
                end else if (r_sp_before != '0) begin
                    seg_l      = sat_add(r_seg_len, r_sp_before);
                    n_seg_dots = 1'b0;
                end
                n_pend_slash = 1'b0;
                n_sp_before  = '0;
                n_sp_after   = '0;
                n_seg_len    = sat_add(seg_l, 2'd1);
                if (cur_byte != CH_DOT) begin
                    n_seg_dots = 1'b0;
                end
                if (!is_whitelisted(cur_byte)) begin
                    n_flags.illegal = 1'b1;
                end
                n_commit = r_emit_cnt + CNT_W'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitting   <= 1'b0;
            r_emit_cnt   <= '0;
            r_commit     <= '0;
            r_pend_slash <= 1'b0;
            r_sp_before  <= '0;
            r_sp_after   <= '0;
            r_seg_len    <= '0;
            r_seg_dots   <= 1'b1;
            r_flags      <= '0;
            r_step       <= OP_BYTE0;
        end else if (advance) begin
            r_emitting   <= n_emitting;
            r_emit_cnt   <= n_emit_cnt;
            r_commit     <= n_commit;
            r_pend_slash <= n_pend_slash;
            r_sp_before  <= n_sp_before;
            r_sp_after   <= n_sp_after;
            r_seg_len    <= n_seg_len;
            r_seg_dots   <= n_seg_dots;
            r_flags      <= n_flags;
            r_step       <= n_step;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= has_result;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== sv/path_sanitizer_stream_unit.sv =====
// path_sanitizer_stream_unit: top level of the path sanitizer stream
// depends on pss_pkg, pss_front, pss_queue and pss_back
//
// Usage: one path byte per input transaction (has_char, ch, end_of_path); a
// transaction with has_char low and end_of_path high ends an empty path.
// Results leave on the output channel: a tentative byte with its index for every
// byte after the leading strip, then one final transaction with status and kept
// length, marked by last_result.
// Throughput: one input transaction per cycle while the four-entry queue has room;
// the back part retires one operation per cycle while the queue is not empty and the
// output is not stalled; one byte or a bare path end is one operation, two bytes (the
// held byte when no drive prefix follows) or a byte plus the path end are two, and two
// bytes plus the path end three, one result each but for stripped bytes. An accepted
// input passes the queue and the output register. A receiver stall holds the output
// register and stops the back part; the queue then fills and o_in_stall rises.
// Reset (synchronous, active low) empties the queue, clears all path state and
// sets allow_subdirs to 1. allow_subdirs is written over the APB port at byte
// address 0 (bit 0); the user writes it only while the block is idle, which the block does not enforce.
module path_sanitizer_stream_unit
    import pss_pkg::*;
#(
    parameter int MAX_PATH_LEN = DEF_MAX_PATH_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic      r_allow_subdirs;
    logic      reg_hit;
    logic      in_accept;
    logic      q_push;
    logic      q_pop;
    t_q_entry  q_in;
    t_q_entry  q_head;
    t_q_status q_stat;

    // register decode
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1:2] == REG_ALLOW_SUBDIRS);
    assign prdata  = reg_hit ? APB_DW'(r_allow_subdirs) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_subdirs <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_allow_subdirs <= pwdata[0];
        end
    end

    // input handshake
    assign o_in_stall = q_stat.full;
    assign in_accept  = i_in_valid && !q_stat.full;

    pss_front #(
        .MAX_PATH_LEN (MAX_PATH_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    pss_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (q_in),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_stat)
    );

    pss_back #(
        .MAX_PATH_LEN (MAX_PATH_LEN)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (q_head),
        .i_q_status      (q_stat),
        .i_allow_subdirs (r_allow_subdirs),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out           (o_out)
    );

    // queue never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    // tentative results carry no status, length or last mark
    a_tentative_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.is_final) |->
            (o_out.status == ST_OK) && (o_out.norm_length == '0) && !o_out.last_result)
        else $error("tentative result carries final fields");

    // a failing path reports zero kept length
    a_error_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.is_final && o_out.status != ST_OK) |->
            (o_out.norm_length == '0) && o_out.last_result)
        else $error("error status with nonzero length");

endmodule

// ===== verif/tb_path_sanitizer_stream_unit.sv =====
// tb_path_sanitizer_stream_unit: self-checking testbench for the path sanitizer stream
// random and directed paths against a cycle-free predictor, random idling on both channels
// depends on pss_pkg and path_sanitizer_stream_unit
`timescale 1ns / 100ps

module tb_path_sanitizer_stream_unit;
    import pss_pkg::*;

    localparam int MAX_LEN = DEF_MAX_PATH_LEN;
    localparam logic [APB_AW-1:0] ADDR_ALLOW = APB_AW'(4 * REG_ALLOW_SUBDIRS);
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS = 200;
    localparam longint LIMIT_NS = 64'd20_000_000;

    // predictor phases of one path
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_HOLD  = 2'd1,
        PH_STRIP = 2'd2,
        PH_EMIT  = 2'd3
    } t_pred_phase;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    path_sanitizer_stream_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and scoreboard storage
    t_in_item   path_items[$];
    t_out_item  expected_results[$];
    logic [7:0] path_buf[$];
    int         err_cnt = 0;

    // predictor state
    bit          cfg_allow;
    int unsigned raw_cnt;
    int unsigned emit_cnt;
    int unsigned kept_len;
    logic [7:0]  held_byte;
    t_pred_phase ph;
    bit          slash_pend;
    bit          seg_dots;
    logic [1:0]  sp_before;
    logic [1:0]  sp_after;
    logic [1:0]  seg_len;
    t_err_flags  err;

    // driver and receiver idling state
    bit in_taken = 1'b0;
    bit drv_busy = 1'b0;
    bit no_gaps = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int launches = 0;

    // ---------------------------------------------------------------- predictor

    function automatic void clear_path_state();
        raw_cnt = 0;
        emit_cnt = 0;
        kept_len = 0;
        held_byte = 8'h00;
        ph = PH_FIRST;
        slash_pend = 1'b0;
        seg_dots = 1'b1;
        sp_before = 2'd0;
        sp_after = 2'd0;
        seg_len = 2'd0;
        err = '0;
    endfunction

    function automatic logic [1:0] sat_add(logic [1:0] v, logic [1:0] d);
        int s;
        s = v + d;
        return (s > 3) ? 2'd3 : s[1:0];
    endfunction

    function automatic bit alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // allowed path characters
    function automatic bit char_ok(logic [7:0] c);
        if (alpha(c) || (c >= "0" && c <= "9"))
            return 1'b1;
        case (c)
            "/", ".", "_", "-", " ", "(", ")", "+", ",": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void post_result(bit fin, logic [7:0] b, int unsigned idx,
                                        int unsigned len, t_status st);
        t_out_item r;
        r.is_final = fin;
        r.out_byte = b;
        r.out_index = idx[9:0];
        r.norm_length = len[10:0];
        r.status = st;
        r.last_result = fin;
        expected_results.push_back(r);
    endfunction

    // one mapped byte after the drive prefix check
    function automatic void sanitize_byte(logic [7:0] b);
        bit trim;
        trim = (b == CH_SLASH) || (b == CH_SPACE);
        if (ph == PH_STRIP) begin
            if (trim)
                return;
            ph = PH_EMIT;
        end
        post_result(1'b0, b, emit_cnt, 0, ST_OK);
        emit_cnt++;
        // trailing candidates stay pending until a kept byte follows
        if (trim) begin
            if (b == CH_SLASH) begin
                slash_pend = 1'b1;
                sp_after = 2'd0;
            end else if (slash_pend) begin
                sp_after = sat_add(sp_after, 2'd1);
            end else begin
                sp_before = sat_add(sp_before, 2'd1);
            end
            return;
        end
        // kept byte: pending run joins the path
        if (slash_pend) begin
            if (sp_before == 0 && seg_len == 2 && seg_dots)
                err.traversal = 1'b1;
            err.slash = 1'b1;
            seg_len = sp_after;
            seg_dots = (sp_after == 0);
        end else if (sp_before != 0) begin
            seg_len = sat_add(seg_len, sp_before);
            seg_dots = 1'b0;
        end
        slash_pend = 1'b0;
        sp_before = 2'd0;
        sp_after = 2'd0;
        seg_len = sat_add(seg_len, 2'd1);
        if (b != CH_DOT)
            seg_dots = 1'b0;
        if (!char_ok(b))
            err.illegal = 1'b1;
        kept_len = emit_cnt;
    endfunction

    // expected results of one accepted transaction
    function automatic void sanitize_step(t_in_item it);
        logic [7:0] b;
        t_status    st;
        b = it.ch;
        if (it.has_char) begin
            if (raw_cnt <= MAX_LEN)
                raw_cnt++;
            if (raw_cnt <= MAX_LEN) begin
                if (b == CH_BACKSLASH)
                    b = CH_SLASH;
                case (ph)
                    PH_FIRST: begin
                        held_byte = b;
                        ph = PH_HOLD;
                    end
                    PH_HOLD: begin
                        ph = PH_STRIP;
                        if (!(b == CH_COLON && alpha(held_byte))) begin
                            sanitize_byte(held_byte);
                            sanitize_byte(b);
                        end
                    end
                    default: sanitize_byte(b);
                endcase
            end
        end
        if (it.end_of_path) begin
            if (ph == PH_HOLD) begin
                ph = PH_STRIP;
                sanitize_byte(held_byte);
            end
            if (kept_len != 0 && seg_len == 2 && seg_dots)
                err.traversal = 1'b1;
            if (raw_cnt == 0)
                st = ST_EMPTY;
            else if (raw_cnt > MAX_LEN)
                st = ST_TOO_LONG;
            else if (kept_len == 0)
                st = ST_EMPTY_TRIM;
            else if (err.traversal)
                st = ST_TRAVERSAL;
            else if (err.illegal)
                st = ST_ILLEGAL;
            else if (err.slash && !cfg_allow)
                st = ST_SUBDIR;
            else
                st = ST_OK;
            post_result(1'b1, 8'h00, 0, (st == ST_OK) ? kept_len : 0, st);
            clear_path_state();
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic t_in_item make_item(bit h, logic [7:0] c, bit e);
        t_in_item it;
        it.has_char = h;
        it.ch = c;
        it.end_of_path = e;
        return it;
    endfunction

    function automatic void push_text(string s);
        for (int k = 0; k < s.len(); k++)
            path_items.push_back(make_item(1'b1, s[k], k == s.len() - 1));
    endfunction

    function automatic void add_text(string s);
        for (int k = 0; k < s.len(); k++)
            path_buf.push_back(s[k]);
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) == 0) ? 8'(8'h61 + $urandom_range(0, 25))
                                            : 8'(8'h41 + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] name_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return rand_letter();
        if (r < 70)
            return 8'(8'h30 + $urandom_range(0, 9));
        if (r < 94) begin
            case ($urandom_range(0, 7))
                0: return "_";
                1: return "-";
                2: return "(";
                3: return ")";
                4: return "+";
                5: return ",";
                6: return ".";
                default: return " ";
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_seg();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            n = $urandom_range(1, 5);
            repeat (n) path_buf.push_back(name_char());
        end else if (r < 60) begin
            add_text("..");
        end else if (r < 67) begin
            add_text(".");
        end else if (r < 72) begin
            add_text("...");
        end else if (r < 77) begin
            add_text(" ..");
        end else if (r < 82) begin
            add_text(".. ");
        end else if (r < 86) begin
            add_text(". .");
        end else if (r < 93) begin
            add_text("  ");
            path_buf.push_back(name_char());
        end else begin
            path_buf.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void add_sep();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            add_text("/");
        else if (r < 80)
            path_buf.push_back(CH_BACKSLASH);
        else if (r < 87)
            add_text(" /");
        else if (r < 94)
            add_text("/ ");
        else
            add_text("//");
    endfunction

    // leading or trailing run of separators and spaces
    function automatic void add_junk();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0: path_buf.push_back(CH_SLASH);
                1: path_buf.push_back(CH_SPACE);
                default: path_buf.push_back(CH_BACKSLASH);
            endcase
        end
    endfunction

    // move the built path into the transaction queue, returns its byte count plus one for a separate end
    function automatic int flush_path();
        int n;
        bit split;
        n = path_buf.size();
        split = (n == 0) || ($urandom_range(0, 4) == 0);
        foreach (path_buf[k]) begin
            if ($urandom_range(0, 19) == 0)
                path_items.push_back(make_item(1'b0, 8'($urandom_range(0, 255)), 1'b0));
            path_items.push_back(make_item(1'b1, path_buf[k], !split && k == n - 1));
        end
        if (split) begin
            path_items.push_back(make_item(1'b0, 8'($urandom_range(0, 255)), 1'b1));
            n++;
        end
        path_buf.delete();
        return n;
    endfunction

    function automatic int gen_path();
        int r;
        int n;
        path_buf.delete();
        r = $urandom_range(0, 99);
        if (r < 10) begin
            // raw noise, possibly an empty path
            n = $urandom_range(0, 6);
            repeat (n) path_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            if (r < 25) begin
                path_buf.push_back(rand_letter());
                path_buf.push_back(CH_COLON);
            end else if (r < 30) begin
                path_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
                path_buf.push_back(CH_COLON);
            end
            if ($urandom_range(0, 5) == 0)
                add_junk();
            n = $urandom_range(1, 4);
            for (int s = 0; s < n; s++) begin
                if (s > 0)
                    add_sep();
                add_seg();
            end
            if ($urandom_range(0, 4) == 0)
                add_junk();
        end
        return flush_path();
    endfunction

    function automatic void gen_long(int n);
        path_buf.delete();
        repeat (n) path_buf.push_back(rand_letter());
        path_buf[n / 2] = CH_SLASH;
        void'(flush_path());
    endfunction

    function automatic void fill_random(int target);
        int done;
        done = 0;
        while (done < target)
            done += gen_path();
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------- channels

    // input acceptance and prediction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sanitize_step(i_in);
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
    end

    // input driver, one transaction held until accepted
    always @(negedge i_clk) begin
        if (in_taken)
            drv_busy = 1'b0;
        if (i_rst_n && !drv_busy) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (path_items.size() > 0) begin
                i_in <= path_items.pop_front();
                drv_busy = 1'b1;
                launches++;
                if (launches % 32 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                gap_left = no_gaps ? 0 : idle_len();
            end
        end
        i_in_valid <= drv_busy;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = no_gaps ? 0 : idle_len();
        end
    end

    function automatic void check_field(string name, logic [10:0] want, logic [10:0] got);
        if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $error("unexpected result transaction: %h", o_out);
            end else begin
                want = expected_results.pop_front();
                check_field("is_final", 11'(want.is_final), 11'(o_out.is_final));
                check_field("out_byte", 11'(want.out_byte), 11'(o_out.out_byte));
                check_field("out_index", 11'(want.out_index), 11'(o_out.out_index));
                check_field("norm_length", want.norm_length, o_out.norm_length);
                check_field("status", 11'(want.status), 11'(o_out.status));
                check_field("last_result", 11'(want.last_result), 11'(o_out.last_result));
            end
        end
    end

    // ---------------------------------------------------------------- register port

    task automatic reg_write(logic [APB_AW-1:0] a, logic [APB_DW-1:0] d);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (a == ADDR_ALLOW)
            cfg_allow = d[0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_read_check(logic [APB_AW-1:0] a);
        logic [APB_DW-1:0] want;
        want = {{(APB_DW - 1){1'b0}}, cfg_allow};
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= a;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            err_cnt++;
            $error("prdata: expected %h, got %h", want, prdata);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // sender stops until all results are back and the block has settled
    task automatic wait_idle();
        while (path_items.size() != 0 || drv_busy || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin : main_seq
        cfg_allow = 1'b1;
        clear_path_state();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        reg_read_check(ADDR_ALLOW);

        // directed: idle, empty, single byte, drive prefix, strip, illegal extremes
        path_items.push_back(make_item(1'b0, 8'h00, 1'b0));
        path_items.push_back(make_item(1'b0, 8'hFF, 1'b1));
        push_text("a");
        push_text("Z:\\");
        push_text("/ ..");
        path_items.push_back(make_item(1'b1, 8'hFF, 1'b1));
        path_items.push_back(make_item(1'b1, 8'h00, 1'b0));
        path_items.push_back(make_item(1'b0, 8'h00, 1'b1));
        push_text("a\\b ");
        push_text("1:");
        push_text(".. /x");
        wait_idle();

        // subdirectories rejected, with a full drain in the middle
        reg_write(ADDR_ALLOW, 0);
        reg_read_check(ADDR_ALLOW);
        fill_random(45);
        wait_idle();
        fill_random(45);
        wait_idle();

        // subdirectories allowed, longest and over-long paths
        reg_write(ADDR_ALLOW, 1);
        reg_read_check(ADDR_ALLOW);
        gen_long(MAX_LEN);
        gen_long(MAX_LEN + 1);
        fill_random(80);
        wait_idle();

        reg_write(ADDR_ALLOW, 0);
        reg_read_check(ADDR_ALLOW);
        fill_random(80);
        wait_idle();

        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/pss_pkg.sv
sv/pss_front.sv
sv/pss_queue.sv
sv/pss_back.sv
sv/path_sanitizer_stream_unit.sv
verif/tb_path_sanitizer_stream_unit.sv
